/* rtl/ntbu_pkg.sv */
// ----------------------------------------------------------------------------
// ntbu_pkg: shared types and arithmetic helpers for the neuron trace update
// Holds the item structs, the per-unit state entry, register codes and the
// Q8.24 rounding and saturation functions used by the pipeline stages.
// ----------------------------------------------------------------------------
package ntbu_pkg;

	localparam int IDX_W      = 10;
	localparam int UNITS      = 1 << IDX_W;
	localparam int UPC        = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int RATE_W     = 25;
	localparam int LOG_STEPS  = 24;

	localparam logic [RATE_W-1:0] ONE_Q24 = RATE_W'(1 << 24);
	localparam logic signed [31:0] P_INIT = 32'((16777216 + UPC / 2) / UPC);
	localparam logic signed [30:0] LN2_Q30 = 31'sd744261118;
	localparam logic signed [63:0] S32_MAX = 64'sh000000007FFFFFFF;
	localparam logic signed [63:0] S32_MIN = 64'shFFFFFFFF80000000;
	localparam logic signed [31:0] BIAS_MIN = 32'sh80000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROB_RATE  = 3'd0,
		CFG_ELIG_RATE  = 3'd1,
		CFG_Z_DECAY    = 3'd2,
		CFG_CUR_DECAY  = 3'd3,
		CFG_SPIKE_INC  = 3'd4,
		CFG_BIAS_GAIN  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [RATE_W-1:0] prob_rate;
		logic [RATE_W-1:0] elig_rate;
		logic [RATE_W-1:0] z_decay;
		logic [RATE_W-1:0] current_decay;
		logic [30:0]       spike_increment;
		logic signed [31:0] bias_gain;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		prob_rate: '0, elig_rate: '0, z_decay: '0, current_decay: '0,
		spike_increment: '0, bias_gain: 32'sh01000000
	};

	typedef struct packed {
		logic [IDX_W-1:0] unit_index;
		logic             spiked;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] bias_value;
		logic               bias_valid;
		logic signed [31:0] prob_trace;
		logic signed [31:0] decayed_current;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] p;
		logic signed [31:0] e;
		logic signed [31:0] z;
		logic signed [31:0] cur;
	} entry_t;

	localparam entry_t ENTRY_INIT = '{p: P_INIT, e: '0, z: '0, cur: '0};

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} stage_info_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} wr_req_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		entry_t           val;
	} trace_res_t;

	function automatic logic [RATE_W-1:0] clamp_rate(input logic [CFG_DATA_W-1:0] v);
		logic [RATE_W-1:0] r;
		r = v[RATE_W-1:0];
		return (r > ONE_Q24) ? ONE_Q24 : r;
	endfunction

	// Round to nearest with ties toward plus infinity, Q.48 down to Q.24.
	function automatic logic signed [63:0] rnd_q24(input logic signed [63:0] v);
		return (v + 64'sd8388608) >>> 24;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* rtl/ntbu_state_mem.sv */
// ----------------------------------------------------------------------------
// ntbu_state_mem: per-unit state memory
// One write port and one read port; the read data is registered, and a read
// of an entry written at the same edge returns the old contents.
// ----------------------------------------------------------------------------
module ntbu_state_mem import ntbu_pkg::*; (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	input  logic             we,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);

	entry_t mem [UNITS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/ntbu_trace_update.sv */
// ----------------------------------------------------------------------------
// ntbu_trace_update: read-modify-write of the current and the z, e, p traces
// Stage 1 holds the memory read data (with forwarding from the last write)
// and forms the products, stage 2 rounds, saturates and writes back, and
// stage 3 holds the written entry for forwarding and for the bias pipeline.
// ----------------------------------------------------------------------------
module ntbu_trace_update import ntbu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        accept,
	input  in_item_t    in_item,
	input  cfg_t        cfg,
	input  entry_t      rd_data,
	output stage_info_t s1_info,
	output wr_req_t     wr_req,
	output trace_res_t  res
);

	logic             vld_s1, vld_s2, vld_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic             spk_s1, spk_s2;
	entry_t           val_s3;

	entry_t                 cur_st;
	logic [RATE_W-1:0]      fac_c, fac_z;
	logic signed [32:0]     d_pe, d_ze;
	logic signed [57:0]     prod_c, prod_z;
	logic signed [58:0]     prod_p, prod_e;

	logic signed [57:0] prod_c_s2, prod_z_s2;
	logic signed [58:0] prod_p_s2, prod_e_s2;
	logic signed [31:0] p_s2, e_s2;
	entry_t             nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// The entry that stage 3 holds was written at the same edge as the read and is not visible in the read data.
	always_comb begin
		cur_st = (vld_s3 && idx_s3 == idx_s1) ? val_s3 : rd_data;
		fac_c  = ONE_Q24 - cfg.current_decay;
		fac_z  = ONE_Q24 - cfg.z_decay;
		d_pe   = 33'(cur_st.e) - 33'(cur_st.p);
		d_ze   = 33'(cur_st.z) - 33'(cur_st.e);
		prod_c = cur_st.cur * $signed({1'b0, fac_c});
		prod_z = cur_st.z * $signed({1'b0, fac_z});
		prod_p = d_pe * $signed({1'b0, cfg.prob_rate});
		prod_e = d_ze * $signed({1'b0, cfg.elig_rate});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1    <= in_item.unit_index;
			spk_s1    <= in_item.spiked;
			idx_s2    <= idx_s1;
			spk_s2    <= spk_s1;
			p_s2      <= cur_st.p;
			e_s2      <= cur_st.e;
			prod_c_s2 <= prod_c;
			prod_z_s2 <= prod_z;
			prod_p_s2 <= prod_p;
			prod_e_s2 <= prod_e;
			idx_s3    <= idx_s2;
			val_s3    <= nxt;
		end
	end

	always_comb begin
		nxt.cur = sat32(rnd_q24(64'(prod_c_s2)));
		nxt.p   = sat32(64'(p_s2) + rnd_q24(64'(prod_p_s2)));
		nxt.e   = sat32(64'(e_s2) + rnd_q24(64'(prod_e_s2)));
		nxt.z   = sat32(rnd_q24(64'(prod_z_s2))
			+ (spk_s2 ? $signed(64'(cfg.spike_increment)) : 64'sd0));
	end

	assign wr_req  = '{we: vld_s2 && en, addr: idx_s2, data: nxt};
	assign s1_info = '{vld: vld_s1, idx: idx_s1};
	assign res     = '{vld: vld_s3, idx: idx_s3, val: val_s3};

	// The input interlock keeps two updates of one unit out of stages 1 and 2.
	a_no_s1_s2_clash: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 |-> idx_s1 != idx_s2)
		else $error("same unit in stages 1 and 2");

endmodule

/* rtl/ntbu_bias_pipe.sv */
// ----------------------------------------------------------------------------
// ntbu_bias_pipe: bias = gain * ln(p), pipelined
// A normalize stage, one squaring stage per fraction bit of log2, then the
// ln 2 scaling and the gain multiply, each behind its own register.
// ----------------------------------------------------------------------------
module ntbu_bias_pipe import ntbu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  trace_res_t        din,
	input  logic signed [31:0] gain,
	input  logic              bias_en,
	output logic              res_vld,
	output out_item_t         res
);

	typedef struct packed {
		logic               p_pos;
		logic signed [31:0] np;
		logic signed [31:0] ncur;
	} tag_t;

	logic               vld_s [LOG_STEPS+1];
	tag_t               tag_s [LOG_STEPS+1];
	logic [30:0]        m_s   [LOG_STEPS+1];
	logic signed [5:0]  k_s   [LOG_STEPS+1];
	logic [23:0]        fr_s  [LOG_STEPS+1];

	logic [4:0]         msb;
	logic [30:0]        m_norm;
	logic signed [5:0]  k_norm;

	logic               vld_ln, vld_g;
	tag_t               tag_ln, tag_g;
	logic signed [31:0] lg;
	logic signed [62:0] ln_prod_q;
	logic signed [31:0] ln_val;
	logic signed [63:0] g_prod_q;

	// Integer part of log2 and the mantissa in Q1.30.
	always_comb begin
		msb = '0;
		for (int i = 0; i < 31; i++) begin
			if (din.val.p[i]) begin
				msb = 5'(i);
			end
		end
		m_norm = din.val.p[30:0] << (5'd30 - msb);
		k_norm = $signed({1'b0, msb}) - 6'sd24;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= '{p_pos: din.val.p > 32'sd0, np: din.val.p, ncur: din.val.cur};
			m_s[0]   <= m_norm;
			k_s[0]   <= k_norm;
			fr_s[0]  <= '0;
		end
	end

	for (genvar g = 1; g <= LOG_STEPS; g++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] top;

		assign sq  = m_s[g-1] * m_s[g-1];
		assign top = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_s[g-1];
			end
		end

		// A square at or above 2.0 yields a one bit and is halved.
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[g]   <= top[31] ? top[31:1] : top[30:0];
				fr_s[g]  <= {fr_s[g-1][22:0], top[31]};
				k_s[g]   <= k_s[g-1];
				tag_s[g] <= tag_s[g-1];
			end
		end
	end

	assign lg     = {{2{k_s[LOG_STEPS][5]}}, k_s[LOG_STEPS], fr_s[LOG_STEPS]};
	assign ln_val = 32'((64'(ln_prod_q) + 64'sd536870912) >>> 30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ln <= 1'b0;
			vld_g  <= 1'b0;
		end else if (en) begin
			vld_ln <= vld_s[LOG_STEPS];
			vld_g  <= vld_ln;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ln_prod_q <= lg * LN2_Q30;
			tag_ln    <= tag_s[LOG_STEPS];
			g_prod_q  <= gain * ln_val;
			tag_g     <= tag_ln;
		end
	end

	always_comb begin
		res_vld             = vld_g;
		res.bias_valid      = bias_en;
		res.prob_trace      = tag_g.np;
		res.decayed_current = tag_g.ncur;
		if (!bias_en) begin
			res.bias_value = '0;
		end else if (!tag_g.p_pos) begin
			res.bias_value = BIAS_MIN;
		end else begin
			res.bias_value = sat32(rnd_q24(g_prod_q));
		end
	end

endmodule

/* rtl/neuron_trace_bias_update_top.sv */
// ----------------------------------------------------------------------------
// neuron_trace_bias_update_top: per-unit trace update with ln(p) bias
// Top level: configuration registers, memory clearing, input interlock,
// output register, and the memory, trace and bias pipelines.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while in_ready is high and
// presents the results in order. Unit state sits in a 1024-entry memory that
// is read, updated over two stages and written back; a transaction for the
// same unit as the one accepted just before it waits for that one to leave
// the multiply stage. After reset the block writes the initial state into
// all 1024 entries of the memory, with in_ready low; register writes are
// taken throughout. The bias is formed by a 24-stage squaring pipeline for
// log2, so it adds no stall. While a result waits in the output register
// with out_ready low, the whole pipeline holds.
module neuron_trace_bias_update_top import ntbu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t             cfg_q;
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic             out_valid_q;
	out_item_t        out_item_q;

	logic        en, hazard, accept;
	stage_info_t s1_info;
	wr_req_t     wr_req;
	trace_res_t  trace_res;
	entry_t      rd_data;
	logic        res_vld;
	out_item_t   res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PROB_RATE: cfg_q.prob_rate       <= clamp_rate(cfg_data);
				CFG_ELIG_RATE: cfg_q.elig_rate       <= clamp_rate(cfg_data);
				CFG_Z_DECAY:   cfg_q.z_decay         <= clamp_rate(cfg_data);
				CFG_CUR_DECAY: cfg_q.current_decay   <= clamp_rate(cfg_data);
				CFG_SPIKE_INC: cfg_q.spike_increment <= cfg_data[30:0];
				CFG_BIAS_GAIN: cfg_q.bias_gain       <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == IDX_W'(UNITS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign en       = !out_valid_q || out_ready;
	assign hazard   = s1_info.vld && s1_info.idx == in_item.unit_index;
	assign in_ready = en && !clr_busy_q && !hazard;
	assign accept   = in_valid && in_ready;

	ntbu_state_mem u_mem (
		.clk     (clk),
		.rd_en   (en),
		.rd_addr (in_item.unit_index),
		.rd_data (rd_data),
		.we      (clr_busy_q || wr_req.we),
		.wr_addr (clr_busy_q ? clr_addr_q : wr_req.addr),
		.wr_data (clr_busy_q ? ENTRY_INIT : wr_req.data)
	);

	ntbu_trace_update u_trace (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.accept  (accept),
		.in_item (in_item),
		.cfg     (cfg_q),
		.rd_data (rd_data),
		.s1_info (s1_info),
		.wr_req  (wr_req),
		.res     (trace_res)
	);

	ntbu_bias_pipe u_bias (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.din     (trace_res),
		.gain    (cfg_q.bias_gain),
		.bias_en (cfg_q.prob_rate != '0),
		.res_vld (res_vld),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ready)
		else $error("transaction accepted during memory clearing");

	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && s1_info.vld |-> s1_info.idx != in_item.unit_index)
		else $error("same unit accepted behind itself");

	a_bias_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.bias_valid |-> out_item.bias_value == '0)
		else $error("bias value nonzero while bias disabled");

endmodule
